[rtl/psgt_pkg.sv]
// Shared widths, table size and row type for the sequence gap tracker.
package psgt_pkg;

    localparam int TABLE_ENTRIES = 32;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int ADDR_W        = 64;
    localparam int SEQ_W         = 32;
    localparam int TIME_W        = 32;

    typedef struct packed {
        logic [ADDR_W-1:0] addr_high;
        logic [ADDR_W-1:0] addr_low;
        logic [SEQ_W-1:0]  prev_seq;
    } t_row;

endpackage

[rtl/psgt_ifs.sv]
// Valid/ready channel interfaces for packet items and result items.
interface psgt_in_if
    import psgt_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] src_addr_high;
    logic [ADDR_W-1:0] src_addr_low;
    logic              parse_ok;
    logic [SEQ_W-1:0]  sequence_number;
    logic [TIME_W-1:0] send_time;
    logic [TIME_W-1:0] receive_time;

    modport source (
        output valid, src_addr_high, src_addr_low, parse_ok,
               sequence_number, send_time, receive_time,
        input  ready
    );
    modport sink (
        input  valid, src_addr_high, src_addr_low, parse_ok,
               sequence_number, send_time, receive_time,
        output ready
    );
endinterface

interface psgt_out_if
    import psgt_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [TIME_W-1:0] rx_delay;
    logic [SEQ_W-1:0]  gap_count;
    logic              no_slot;

    modport source (output valid, rx_delay, gap_count, no_slot, input ready);
    modport sink   (input valid, rx_delay, gap_count, no_slot, output ready);
endinterface

[rtl/per_sender_sequence_gap_tracker.sv]
// Top level: per-sender sequence gap and delay tracker with a walked sender table.
//
//  channel  | dir | payload
//  ---------+-----+---------------------------------------------------------------
//  i_in     | in  | src_addr_high, src_addr_low, parse_ok, sequence_number,
//           |     | send_time, receive_time
//  o_out    | out | rx_delay, gap_count, no_slot
//
// An item goes from accept to the next accept through one read of the sender
// table per entry through its single read port, a drain step for the last
// compare, an update step that writes the table and loads the result, and a
// return to idle to accept; no new item is taken before that.
// The table walk uses one 128-bit address comparator shared by every entry.
// Reset clears the per-entry valid bits at once; table rows need no clearing.
// The result register lets a new item be accepted while a result waits; the
// update step holds until that register is free.
module per_sender_sequence_gap_tracker
    import psgt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    psgt_in_if.sink     i_in,
    psgt_out_if.source  o_out
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_WALK   = 2'd1;
    localparam logic [1:0] S_DRAIN  = 2'd2;
    localparam logic [1:0] S_UPDATE = 2'd3;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);

    // sender table
    t_row r_mem [TABLE_ENTRIES];
    t_row r_rd_row;

    logic [TABLE_ENTRIES-1:0] r_valid, n_valid;
    logic [1:0]       r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [IDX_W-1:0] r_cmp_idx;
    logic             r_cmp_vld, n_cmp_vld;
    logic             r_hit_found, n_hit_found;
    logic             r_free_found, n_free_found;
    logic [IDX_W-1:0] r_hit_idx, n_hit_idx;
    logic [IDX_W-1:0] r_free_idx, n_free_idx;
    logic [SEQ_W-1:0] r_hit_seq, n_hit_seq;
    logic             r_out_vld, n_out_vld;

    // latched packet
    logic [ADDR_W-1:0] r_addr_high;
    logic [ADDR_W-1:0] r_addr_low;
    logic              r_parse_ok;
    logic [SEQ_W-1:0]  r_seq;
    logic [TIME_W-1:0] r_send;
    logic [TIME_W-1:0] r_recv;

    // result register
    logic [TIME_W-1:0] r_delay;
    logic [SEQ_W-1:0]  r_gap;
    logic              r_no_slot;

    logic              in_take;
    logic              out_free;
    logic              addr_match;
    logic              do_update;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;
    t_row              wr_row;
    logic [SEQ_W-1:0]  expect_seq;
    logic [SEQ_W-1:0]  gap_val;
    logic [TIME_W-1:0] delay_val;

    assign i_in.ready = (r_state == S_IDLE);
    assign in_take    = i_in.valid && i_in.ready;
    assign out_free   = !r_out_vld || o_out.ready;
    assign do_update  = (r_state == S_UPDATE) && out_free;

    // the one shared comparator
    assign addr_match = (r_rd_row.addr_high == r_addr_high) &&
                        (r_rd_row.addr_low == r_addr_low);

    // claimed entries start from last sequence 0
    assign expect_seq = (r_hit_found ? r_hit_seq : '0) + SEQ_W'(1);
    assign gap_val    = (r_parse_ok && (r_hit_found || r_free_found) && (r_seq > expect_seq))
                        ? (r_seq - expect_seq) : '0;
    assign delay_val  = r_parse_ok ? (r_recv - r_send) : '0;

    assign wr_en  = do_update && (r_hit_found || r_free_found);
    assign wr_idx = r_hit_found ? r_hit_idx : r_free_idx;
    always_comb begin
        wr_row.addr_high = r_addr_high;
        wr_row.addr_low  = r_addr_low;
        if (r_parse_ok) begin
            wr_row.prev_seq = r_seq;
        end else if (r_hit_found) begin
            wr_row.prev_seq = r_hit_seq;
        end else begin
            wr_row.prev_seq = '0;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_cmp_vld    = 1'b0;
        n_hit_found  = r_hit_found;
        n_free_found = r_free_found;
        n_hit_idx    = r_hit_idx;
        n_free_idx   = r_free_idx;
        n_hit_seq    = r_hit_seq;
        n_valid      = r_valid;
        n_out_vld    = r_out_vld && !o_out.ready;

        // compare stage works on the registered read row, in the cycle after the read
        if (r_cmp_vld) begin
            if (r_valid[r_cmp_idx]) begin
                if (!r_hit_found && addr_match) begin
                    n_hit_found = 1'b1;
                    n_hit_idx   = r_cmp_idx;
                    n_hit_seq   = r_rd_row.prev_seq;
                end
            end else if (!r_free_found) begin
                n_free_found = 1'b1;
                n_free_idx   = r_cmp_idx;
            end
        end

        case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    n_state      = S_WALK;
                    n_idx        = '0;
                    n_hit_found  = 1'b0;
                    n_free_found = 1'b0;
                end
            end
            S_WALK: begin
                n_cmp_vld = 1'b1;
                if (r_idx == IDX_LAST) begin
                    n_state = S_DRAIN;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_DRAIN: begin
                n_state = S_UPDATE;
            end
            S_UPDATE: begin
                if (out_free) begin
                    n_state   = S_IDLE;
                    n_out_vld = 1'b1;
                    if (wr_en) begin
                        n_valid[wr_idx] = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_idx        <= '0;
            r_cmp_vld    <= 1'b0;
            r_hit_found  <= 1'b0;
            r_free_found <= 1'b0;
            r_valid      <= '0;
            r_out_vld    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_cmp_vld    <= n_cmp_vld;
            r_hit_found  <= n_hit_found;
            r_free_found <= n_free_found;
            r_valid      <= n_valid;
            r_out_vld    <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit_idx  <= n_hit_idx;
        r_free_idx <= n_free_idx;
        r_hit_seq  <= n_hit_seq;
        r_cmp_idx  <= r_idx;
        if (in_take) begin
            r_addr_high <= i_in.src_addr_high;
            r_addr_low  <= i_in.src_addr_low;
            r_parse_ok  <= i_in.parse_ok;
            r_seq       <= i_in.sequence_number;
            r_send      <= i_in.send_time;
            r_recv      <= i_in.receive_time;
        end
        if (do_update) begin
            r_delay   <= delay_val;
            r_gap     <= gap_val;
            r_no_slot <= !(r_hit_found || r_free_found);
        end
    end

    // table memory: one read port, one write port
    always_ff @(posedge i_clk) begin
        if (r_state == S_WALK) begin
            r_rd_row <= r_mem[r_idx];
        end
        if (wr_en) begin
            r_mem[wr_idx] <= wr_row;
        end
    end

    assign o_out.valid     = r_out_vld;
    assign o_out.rx_delay  = r_delay;
    assign o_out.gap_count = r_gap;
    assign o_out.no_slot   = r_no_slot;

    a_no_slot_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.no_slot) |-> (o_out.gap_count == '0))
        else $error("no_slot result with nonzero gap");

    a_no_slot_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.no_slot) |-> (&r_valid))
        else $error("no_slot reported while a table entry is free");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> !i_in.ready)
        else $error("ready again right after an item was taken");

    a_update_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |=> r_valid[$past(wr_idx)])
        else $error("table write left its entry invalid");

endmodule

[sim/psgt_result_checker.sv]
// Checker for the sequence gap tracker: tracks sender entries, predicts results, compares.
`timescale 1ns / 100ps
module psgt_result_checker
    import psgt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  logic [ADDR_W-1:0] i_src_addr_high,
    input  logic [ADDR_W-1:0] i_src_addr_low,
    input  logic              i_parse_ok,
    input  logic [SEQ_W-1:0]  i_sequence_number,
    input  logic [TIME_W-1:0] i_send_time,
    input  logic [TIME_W-1:0] i_receive_time,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  logic [TIME_W-1:0] i_rx_delay,
    input  logic [SEQ_W-1:0]  i_gap_count,
    input  logic              i_no_slot,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_result_count,
    output int                o_gap_hits,
    output int                o_no_slot_hits
);

    typedef struct packed {
        logic [TIME_W-1:0] rx_delay;
        logic [SEQ_W-1:0]  gap_count;
        logic              no_slot;
    } t_outcome;

    logic     sender_valid [TABLE_ENTRIES];
    t_row     sender_row   [TABLE_ENTRIES];
    t_outcome outcome_q    [$];

    always @(posedge i_clk) begin : watch
        int               hit;
        int               free_idx;
        t_outcome         want;
        t_outcome         res;
        logic [SEQ_W-1:0] next_seq;
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) sender_valid[i] = 1'b0;
            o_fail_count   = 0;
            o_pending      = 0;
            o_result_count = 0;
            o_gap_hits     = 0;
            o_no_slot_hits = 0;
        end else begin
            // results first: an item taken at this edge cannot have its result out yet
            if (i_out_valid && i_out_ready) begin
                o_result_count++;
                if (outcome_q.size() == 0) begin
                    $error("result with no packet pending: rx_delay %h gap_count %h no_slot %b",
                           i_rx_delay, i_gap_count, i_no_slot);
                    o_fail_count++;
                end else begin
                    want = outcome_q.pop_front();
                    if (i_rx_delay !== want.rx_delay) begin
                        $error("rx_delay: expected %h, got %h", want.rx_delay, i_rx_delay);
                        o_fail_count++;
                    end
                    if (i_gap_count !== want.gap_count) begin
                        $error("gap_count: expected %h, got %h", want.gap_count, i_gap_count);
                        o_fail_count++;
                    end
                    if (i_no_slot !== want.no_slot) begin
                        $error("no_slot: expected %b, got %b", want.no_slot, i_no_slot);
                        o_fail_count++;
                    end
                    if (want.gap_count != '0) o_gap_hits++;
                    if (want.no_slot) o_no_slot_hits++;
                end
            end

            if (i_in_valid && i_in_ready) begin
                hit      = -1;
                free_idx = -1;
                res.rx_delay  = i_parse_ok ? i_receive_time - i_send_time : '0;
                res.gap_count = '0;
                res.no_slot   = 1'b0;
                // single pass: first matching live entry, first free entry
                for (int i = 0; i < TABLE_ENTRIES; i++) begin
                    if (sender_valid[i]) begin
                        if (hit < 0 && sender_row[i].addr_high == i_src_addr_high &&
                            sender_row[i].addr_low == i_src_addr_low)
                            hit = i;
                    end else if (free_idx < 0) begin
                        free_idx = i;
                    end
                end
                if (hit < 0 && free_idx >= 0) begin
                    hit = free_idx;
                    sender_valid[hit] = 1'b1;
                    sender_row[hit]   = '{addr_high: i_src_addr_high,
                                          addr_low:  i_src_addr_low,
                                          prev_seq:  '0};
                end
                if (hit < 0) begin
                    res.no_slot = 1'b1;
                end else if (i_parse_ok) begin
                    next_seq = sender_row[hit].prev_seq + 1'b1;
                    if (i_sequence_number > next_seq)
                        res.gap_count = i_sequence_number - next_seq;
                    sender_row[hit].prev_seq = i_sequence_number;
                end
                outcome_q.push_back(res);
            end
            o_pending = outcome_q.size();
        end
    end

endmodule

[sim/per_sender_sequence_gap_tracker_test.sv]
// Testbench top: packet stimulus, result-side stalls and the verdict for the gap tracker.
`timescale 1ns / 100ps
module per_sender_sequence_gap_tracker_test;
    import psgt_pkg::*;

    localparam int RANDOM_PACKETS = 1550;
    localparam int QUIET_TAIL     = 200;
    localparam int POOL           = 40;
    localparam int POOL_TRACKED   = 28;   // with the four directed senders this fills the table
    localparam int DRAIN_CYCLES   = 40;

    localparam logic [ADDR_W-1:0] ADDR_ZERO = '0;
    localparam logic [ADDR_W-1:0] ADDR_ONES = '1;
    localparam logic [SEQ_W-1:0]  SEQ_TOP   = '1;
    localparam logic [TIME_W-1:0] TIME_TOP  = '1;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    bit   quiet   = 1'b0;
    int   sent    = 0;
    int   stall_left = 0;
    int   stall_len;
    int   fail_count, pending, result_count, gap_hits, no_slot_hits;

    logic [ADDR_W-1:0] pool_high [POOL];
    logic [ADDR_W-1:0] pool_low  [POOL];
    logic [SEQ_W-1:0]  pool_seq  [POOL];

    psgt_in_if  in_ch ();
    psgt_out_if out_ch ();

    per_sender_sequence_gap_tracker dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    psgt_result_checker u_check (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (in_ch.valid),
        .i_in_ready        (in_ch.ready),
        .i_src_addr_high   (in_ch.src_addr_high),
        .i_src_addr_low    (in_ch.src_addr_low),
        .i_parse_ok        (in_ch.parse_ok),
        .i_sequence_number (in_ch.sequence_number),
        .i_send_time       (in_ch.send_time),
        .i_receive_time    (in_ch.receive_time),
        .i_out_valid       (out_ch.valid),
        .i_out_ready       (out_ch.ready),
        .i_rx_delay        (out_ch.rx_delay),
        .i_gap_count       (out_ch.gap_count),
        .i_no_slot         (out_ch.no_slot),
        .o_fail_count      (fail_count),
        .o_pending         (pending),
        .o_result_count    (result_count),
        .o_gap_hits        (gap_hits),
        .o_no_slot_hits    (no_slot_hits)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // result side: random stalls on ready
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left   <= stall_left - 1;
            out_ch.ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_len     = $urandom_range(1, 7);
            stall_left   <= stall_len - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    task automatic send_packet(input logic [ADDR_W-1:0] hi, input logic [ADDR_W-1:0] lo,
                               input logic ok, input logic [SEQ_W-1:0] seq,
                               input logic [TIME_W-1:0] ts, input logic [TIME_W-1:0] tr);
        in_ch.valid           <= 1'b1;
        in_ch.src_addr_high   <= hi;
        in_ch.src_addr_low    <= lo;
        in_ch.parse_ok        <= ok;
        in_ch.sequence_number <= seq;
        in_ch.send_time       <= ts;
        in_ch.receive_time    <= tr;
        do @(posedge i_clk); while (!in_ch.ready);
        sent++;
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
    endtask

    initial begin
        int                pick;
        int                r;
        logic              ok;
        logic [ADDR_W-1:0] hi;
        logic [ADDR_W-1:0] lo;
        logic [SEQ_W-1:0]  seq;
        logic [TIME_W-1:0] ts;
        logic [TIME_W-1:0] tr;

        in_ch.valid           = 1'b0;
        in_ch.src_addr_high   = '0;
        in_ch.src_addr_low    = '0;
        in_ch.parse_ok        = 1'b0;
        in_ch.sequence_number = '0;
        in_ch.send_time       = '0;
        in_ch.receive_time    = '0;

        for (int i = 0; i < POOL; i++) begin
            pool_high[i] = {$urandom, $urandom};
            pool_low[i]  = {$urandom, $urandom};
            pool_seq[i]  = '0;
        end
        // near misses on the address compare
        pool_high[1] = pool_high[0];
        pool_low[2]  = pool_low[0];
        pool_high[3] = pool_high[0] ^ 64'h8000_0000_0000_0000;
        pool_low[3]  = pool_low[0];

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: all-zero sender, invalid parse claims with last 0
        send_packet(ADDR_ZERO, ADDR_ZERO, 1'b0, SEQ_TOP, 32'd12, 32'd34);
        send_packet(ADDR_ZERO, ADDR_ZERO, 1'b1, 32'd0, 32'd100, 32'd50);   // delay wraps
        send_packet(ADDR_ZERO, ADDR_ZERO, 1'b1, 32'd1, 32'd7, 32'd7);
        send_packet(ADDR_ZERO, ADDR_ZERO, 1'b1, 32'd10, 32'd0, 32'd3);
        send_packet(ADDR_ZERO, ADDR_ZERO, 1'b0, 32'd1000, 32'd5, 32'd9);   // last stays 10
        send_packet(ADDR_ZERO, ADDR_ZERO, 1'b1, 32'd12, 32'd5, 32'd9);
        send_packet(ADDR_ZERO, ADDR_ZERO, 1'b1, 32'd12, 32'd5, 32'd9);     // repeat
        send_packet(ADDR_ZERO, ADDR_ZERO, 1'b1, 32'd5, 32'd5, 32'd9);      // backwards
        send_packet(ADDR_ZERO, ADDR_ZERO, 1'b1, SEQ_TOP, 32'd1, 32'd2);
        send_packet(ADDR_ZERO, ADDR_ZERO, 1'b1, 32'd0, 32'd1, 32'd2);      // last+1 wraps to 0
        send_packet(ADDR_ZERO, ADDR_ZERO, 1'b1, SEQ_TOP, 32'd1, 32'd2);
        send_packet(ADDR_ZERO, ADDR_ZERO, 1'b1, 32'd3, 32'd1, 32'd2);
        // all-ones sender and time extremes
        send_packet(ADDR_ONES, ADDR_ONES, 1'b1, SEQ_TOP, 32'd0, TIME_TOP);
        send_packet(ADDR_ONES, ADDR_ONES, 1'b1, SEQ_TOP, TIME_TOP, 32'd0);
        // half-matching senders
        send_packet(ADDR_ONES, ADDR_ZERO, 1'b0, 32'd9, TIME_TOP, TIME_TOP);
        send_packet(ADDR_ONES, ADDR_ZERO, 1'b1, 32'd2, 32'd0, 32'd0);
        send_packet(ADDR_ZERO, ADDR_ONES, 1'b1, 32'd0, TIME_TOP, TIME_TOP);
        send_packet(ADDR_ZERO, ADDR_ONES, 1'b1, 32'd1, 32'd40, 32'd41);

        for (int n = 0; n < RANDOM_PACKETS; n++) begin
            quiet = (n >= RANDOM_PACKETS - QUIET_TAIL);
            ts = $urandom;
            tr = ($urandom_range(0, 4) == 0) ? $urandom : ts + $urandom_range(0, 5000);
            r  = $urandom_range(0, 99);
            if (n < POOL_TRACKED) begin
                // introduce tracked senders in turn until the table is full
                pick = n;
                ok   = 1'($urandom_range(0, 1));
                seq  = $urandom_range(0, 20);
            end else if (r < 10) begin
                // noise: unknown sender, random content
                pick = -1;
                ok   = 1'($urandom_range(0, 1));
                seq  = $urandom;
            end else begin
                pick = (r < 87) ? $urandom_range(0, POOL_TRACKED - 1)
                                : $urandom_range(POOL_TRACKED, POOL - 1);
                ok   = ($urandom_range(0, 9) != 0);
                r    = $urandom_range(0, 99);
                if (r < 60)      seq = pool_seq[pick] + 1'b1;
                else if (r < 75) seq = pool_seq[pick] + 1'b1 + $urandom_range(1, 40);
                else if (r < 83) seq = pool_seq[pick] - $urandom_range(0, 5);
                else if (r < 93) seq = $urandom;
                else             seq = SEQ_TOP - $urandom_range(0, 3);
            end
            if (pick < 0) begin
                hi = {$urandom, $urandom};
                lo = {$urandom, $urandom};
            end else begin
                hi = pool_high[pick];
                lo = pool_low[pick];
                if (ok) pool_seq[pick] = seq;
            end
            send_packet(hi, lo, ok, seq, ts, tr);
        end

        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Sent %0d packets: directed extremes, tracked and half-matching senders, %0s",
                 sent, "unknown senders against a full table");
        $display("Checked %0d results: %0d with skipped sequence numbers, %0d without a free entry.",
                 result_count, gap_hits, no_slot_hits);
        if (fail_count == 0)
            $display("per_sender_sequence_gap_tracker_test: clean");
        else
            $display("per_sender_sequence_gap_tracker_test: errors");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("per_sender_sequence_gap_tracker_test: errors");
        $finish;
    end

endmodule
